// ===== src/rusi_pkg.sv =====
// Shared types and constants for the unit-sphere ray intersector.
`timescale 1ns / 1ps
package rusi_pkg;

  localparam int COORD_W = 32;

  typedef logic [COORD_W-1:0] coord_t;

  // Quadratic terms handed from the front end to the root/divide back end.
  typedef struct packed {
    logic         hit;
    logic         hneg;
    logic [63:0]  hmag;
    logic [63:0]  a;
    logic [127:0] disc;
  } quad_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic        sat;
    logic        neg;
    logic [63:0] rem;
    logic [31:0] qd;
  } div_lane_t;

endpackage

// ===== src/rusi_if.sv =====
// Request and result channel interfaces of the ray intersector.
`timescale 1ns / 1ps
interface rusi_req_if;
  import rusi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rusi_res_if;
  import rusi_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t t_near;
  coord_t t_far;
  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

// ===== src/rusi_front.sv =====
// Front end: dot products, half-b, c and the quarter discriminant.
`timescale 1ns / 1ps
module rusi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  rusi_req_if.sink       req,
  output logic           out_valid,
  output rusi_pkg::quad_t out_data,
  input  logic           out_ready
);
  import rusi_pkg::*;

  localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);

  logic [7:1] vld;
  logic       en;

  // stage 1: sign and magnitude
  logic [31:0] mg [6];
  logic [5:0]  sg;
  // stage 2: products
  logic [63:0] pd [3];
  logic [63:0] po [3];
  logic [63:0] pm [3];
  logic [2:0]  pneg;
  // stage 3: sums
  logic [63:0] s_a, s_o2, s_pos, s_neg;
  // stage 4
  logic [63:0] h_mag, h_a, c_mag;
  logic        h_neg, c_pos, h_zero;
  // stage 5: partial products
  logic [63:0] hh_pp [4];
  logic [63:0] ac_pp [4];
  logic [63:0] p5_mag, p5_a;
  logic        p5_neg, p5_cpos, p5_zero;
  // stage 6
  logic [127:0] hh, ac;
  logic [63:0]  p6_mag, p6_a;
  logic         p6_neg, p6_cpos, p6_zero;
  // stage 7
  quad_t q7;

  coord_t in_w [6];

  assign en        = !(vld[7] && !out_ready);
  assign req.ready = en;
  assign out_valid = vld[7];
  assign out_data  = q7;

  assign in_w[0] = req.origin_x;
  assign in_w[1] = req.origin_y;
  assign in_w[2] = req.origin_z;
  assign in_w[3] = req.dir_x;
  assign in_w[4] = req.dir_y;
  assign in_w[5] = req.dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sg[i] <= in_w[i][31];
        mg[i] <= in_w[i][31] ? 32'(-in_w[i]) : in_w[i];
      end
      for (int i = 0; i < 3; i++) begin
        pd[i]   <= 64'(mg[3+i]) * 64'(mg[3+i]);
        po[i]   <= 64'(mg[i]) * 64'(mg[i]);
        pm[i]   <= 64'(mg[3+i]) * 64'(mg[i]);
        pneg[i] <= sg[i] ^ sg[3+i];
      end
      s_a   <= pd[0] + pd[1] + pd[2];
      s_o2  <= po[0] + po[1] + po[2];
      s_pos <= (pneg[0] ? 64'd0 : pm[0]) + (pneg[1] ? 64'd0 : pm[1])
             + (pneg[2] ? 64'd0 : pm[2]);
      s_neg <= (pneg[0] ? pm[0] : 64'd0) + (pneg[1] ? pm[1] : 64'd0)
             + (pneg[2] ? pm[2] : 64'd0);

      h_neg  <= s_neg > s_pos;
      h_mag  <= (s_neg > s_pos) ? s_neg - s_pos : s_pos - s_neg;
      h_a    <= s_a;
      h_zero <= s_a == 64'd0;
      c_pos  <= s_o2 >= ONE2;
      c_mag  <= (s_o2 >= ONE2) ? s_o2 - ONE2 : ONE2 - s_o2;

      hh_pp[0] <= 64'(h_mag[31:0])  * 64'(h_mag[31:0]);
      hh_pp[1] <= 64'(h_mag[31:0])  * 64'(h_mag[63:32]);
      hh_pp[2] <= 64'(h_mag[63:32]) * 64'(h_mag[31:0]);
      hh_pp[3] <= 64'(h_mag[63:32]) * 64'(h_mag[63:32]);
      ac_pp[0] <= 64'(h_a[31:0])    * 64'(c_mag[31:0]);
      ac_pp[1] <= 64'(h_a[31:0])    * 64'(c_mag[63:32]);
      ac_pp[2] <= 64'(h_a[63:32])   * 64'(c_mag[31:0]);
      ac_pp[3] <= 64'(h_a[63:32])   * 64'(c_mag[63:32]);
      p5_mag  <= h_mag;
      p5_a    <= h_a;
      p5_neg  <= h_neg;
      p5_cpos <= c_pos;
      p5_zero <= h_zero;

      hh <= 128'(hh_pp[0]) + (128'(hh_pp[1]) << 32) + (128'(hh_pp[2]) << 32)
          + (128'(hh_pp[3]) << 64);
      ac <= 128'(ac_pp[0]) + (128'(ac_pp[1]) << 32) + (128'(ac_pp[2]) << 32)
          + (128'(ac_pp[3]) << 64);
      p6_mag  <= p5_mag;
      p6_a    <= p5_a;
      p6_neg  <= p5_neg;
      p6_cpos <= p5_cpos;
      p6_zero <= p5_zero;

      // c at or above zero subtracts a*c; a miss when that goes negative
      q7.hit  <= !p6_zero && !(p6_cpos && hh < ac);
      q7.disc <= p6_cpos ? hh - ac : hh + ac;
      q7.hneg <= p6_neg;
      q7.hmag <= p6_mag;
      q7.a    <= p6_a;
    end
  end

endmodule

// ===== src/rusi_fifo.sv =====
// Short register queue between front and back end.
`timescale 1ns / 1ps
module rusi_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rusi_pkg::quad_t push_data,
  output logic            full,
  input  logic            pop,
  output rusi_pkg::quad_t pop_data,
  output logic            empty
);
  import rusi_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  quad_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full     = count == (PW+1)'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (PW+1)'(DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ===== src/rusi_back.sv =====
// Back end: pipelined square root, two restoring dividers, saturation.
`timescale 1ns / 1ps
module rusi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rusi_pkg::quad_t in_data,
  output logic            in_ready,
  rusi_res_if.source      res
);
  import rusi_pkg::*;

  logic en;

  // square root pipeline, index 0 is the queue head
  logic         sq_vld  [65];
  logic [127:0] sq_diff [65];
  logic [63:0]  sq_root [65];
  logic         sq_hit  [65];
  logic         sq_hneg [65];
  logic [63:0]  sq_hmag [65];
  logic [63:0]  sq_a    [65];

  // divider pipelines, index 0 is the numerator stage
  logic        dv_vld [33];
  logic        dv_hit [33];
  logic [63:0] dv_a   [33];
  div_lane_t   dn     [33];
  div_lane_t   df     [33];

  logic        o_vld;
  logic        o_hit;
  coord_t      o_near, o_far;

  assign en        = !o_vld || res.ready;
  assign in_ready  = en;
  assign res.valid = o_vld;
  assign res.hit   = o_hit;
  assign res.t_near = o_near;
  assign res.t_far  = o_far;

  assign sq_vld[0]  = in_valid;
  assign sq_diff[0] = in_data.disc;
  assign sq_root[0] = '0;
  assign sq_hit[0]  = in_data.hit;
  assign sq_hneg[0] = in_data.hneg;
  assign sq_hmag[0] = in_data.hmag;
  assign sq_a[0]    = in_data.a;

  for (genvar k = 0; k < 64; k++) begin : g_sqrt
    localparam int B = 63 - k;
    logic [129:0] trial;
    logic         take;
    assign trial = (130'(sq_root[k]) << (B + 1)) + (130'(1) << (2 * B));
    assign take  = {2'b00, sq_diff[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_diff[k+1] <= take ? sq_diff[k] - trial[127:0] : sq_diff[k];
        sq_root[k+1] <= take ? (sq_root[k] | (64'(1) << B)) : sq_root[k];
        sq_hit[k+1]  <= sq_hit[k];
        sq_hneg[k+1] <= sq_hneg[k];
        sq_hmag[k+1] <= sq_hmag[k];
        sq_a[k+1]    <= sq_a[k];
      end
    end
  end

  // numerators -h - root and -h + root, scaled and checked for overflow
  logic signed [66:0] h_s, n_near, n_far;
  logic [65:0]        m_near, m_far;
  logic [127:0]       w_near, w_far, a_lim;

  assign h_s    = sq_hneg[64] ? $signed({3'b000, sq_hmag[64]})
                              : -$signed({3'b000, sq_hmag[64]});
  assign n_near = h_s - $signed({3'b000, sq_root[64]});
  assign n_far  = h_s + $signed({3'b000, sq_root[64]});
  assign m_near = n_near[66] ? 66'(-n_near) : n_near[65:0];
  assign m_far  = n_far[66]  ? 66'(-n_far)  : n_far[65:0];
  assign w_near = 128'(m_near) << FRAC_BITS;
  assign w_far  = 128'(m_far)  << FRAC_BITS;
  assign a_lim  = 128'(sq_a[64]) << 32;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_hit[0]  <= sq_hit[64];
      dv_a[0]    <= sq_a[64];
      dn[0].sat  <= w_near >= a_lim;
      dn[0].neg  <= n_near[66];
      dn[0].rem  <= w_near[95:32];
      dn[0].qd   <= w_near[31:0];
      df[0].sat  <= w_far >= a_lim;
      df[0].neg  <= n_far[66];
      df[0].rem  <= w_far[95:32];
      df[0].qd   <= w_far[31:0];
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div
    logic [64:0] rn, rf;
    logic        tn, tf;
    assign rn = {dn[k].rem, dn[k].qd[31]};
    assign rf = {df[k].rem, df[k].qd[31]};
    assign tn = rn >= {1'b0, dv_a[k]};
    assign tf = rf >= {1'b0, dv_a[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_hit[k+1]  <= dv_hit[k];
        dv_a[k+1]    <= dv_a[k];
        dn[k+1].sat  <= dn[k].sat;
        dn[k+1].neg  <= dn[k].neg;
        dn[k+1].rem  <= tn ? 64'(rn - {1'b0, dv_a[k]}) : rn[63:0];
        dn[k+1].qd   <= {dn[k].qd[30:0], tn};
        df[k+1].sat  <= df[k].sat;
        df[k+1].neg  <= df[k].neg;
        df[k+1].rem  <= tf ? 64'(rf - {1'b0, dv_a[k]}) : rf[63:0];
        df[k+1].qd   <= {df[k].qd[30:0], tf};
      end
    end
  end

  function automatic coord_t sat_param(input div_lane_t l);
    coord_t r;
    if (!l.neg) begin
      r = (l.sat || l.qd[31]) ? 32'h7FFF_FFFF : l.qd;
    end else begin
      r = (l.sat || l.qd[31]) ? 32'h8000_0000 : 32'(-l.qd);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= dv_vld[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit  <= dv_hit[32];
      o_near <= dv_hit[32] ? sat_param(dn[32]) : '0;
      o_far  <= dv_hit[32] ? sat_param(df[32]) : '0;
    end
  end

endmodule

// ===== src/ray_unit_sphere_intersect_core.sv =====
// Top level: ray against unit sphere, front end, queue and back end.
// Throughput: one ray per cycle when not stalled; the 64-stage root and 32-stage divider set the depth.
// A stalled result holds the back end; the front end runs on until the queue fills.
// Reset (rst, synchronous) clears all valid bits and the queue; data is not cleared.
`timescale 1ns / 1ps
module ray_unit_sphere_intersect_core #(
  parameter int FRAC_BITS  = 16,
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  rusi_req_if.sink   req,
  rusi_res_if.source res
);
  import rusi_pkg::*;

  logic  f_valid, q_full, q_empty, b_ready, q_pop;
  quad_t f_data, q_data;

  rusi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (f_valid),
    .out_data  (f_data),
    .out_ready (!q_full)
  );

  assign q_pop = b_ready && !q_empty;

  rusi_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && !q_full),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  rusi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_data  (q_data),
    .in_ready (b_ready),
    .res      (res)
  );

  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.t_near == '0 && res.t_far == '0)
    else $error("miss with nonzero parameters");
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit |-> $signed(res.t_near) <= $signed(res.t_far))
    else $error("near parameter above far");
  assert property (@(posedge clk) disable iff (rst)
    f_valid && q_full |-> !req.ready)
    else $error("front end advanced into full queue");

endmodule
